// File: sv/block_average_pixelate_core_assert.svh
// assertion macros for the block average pixelate core
`ifndef BLOCK_AVERAGE_PIXELATE_CORE_ASSERT_SVH
`define BLOCK_AVERAGE_PIXELATE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BAP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BAP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BAP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/bap_pkg.sv
// shared types, constants and sizes of the block average pixelate core
package bap_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_BLOCK  = 64;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int BIB_W  = $clog2(MAX_BLOCK);
   localparam int SUM_W  = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
   localparam int AREA_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
   localparam int DCNT_W = $clog2(SUM_W);

   localparam int BS_REG_W  = 7;
   localparam int DIM_REG_W = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } bap_req_type;

   typedef struct packed {
      logic [9:0] block_column;
      logic [9:0] block_row;
      logic [7:0] red_average;
      logic [7:0] green_average;
      logic [7:0] blue_average;
      logic       frame_done;
   } bap_rsp_type;

   typedef struct packed {
      logic accept;
      logic update;
      logic div_step;
      logic load_out;
   } bap_cmd_type;

   typedef struct packed {
      logic emit;
      logic div_last;
      logic out_busy;
   } bap_status_type;

endpackage

// File: sv/bap_ctrl.sv
// controller state machine of the block average pixelate core
module bap_ctrl import bap_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  bap_status_type status,
   output bap_cmd_type    cmd
);

   typedef enum logic [1:0] {S_IDLE, S_UPD, S_DIV, S_OUT} state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) state_in = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = status.emit ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/bap_datapath.sv
// counters, column sum memory, divider and output register
module bap_datapath import bap_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_REG_W-1:0] csr_wdata,
   input  bap_req_type          req_data,
   input  bap_cmd_type          cmd,
   output bap_status_type       status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bap_rsp_type          rsp_data
);

   localparam int MEM_W = 3 * SUM_W;

   logic [BS_REG_W-1:0]  bs_reg_ff;
   logic [DIM_REG_W-1:0] w_reg_ff, h_reg_ff;
   logic [BS_REG_W-1:0]  bs_eff;
   logic [DIM_REG_W-1:0] w_eff, h_eff;

   logic [COL_W-1:0] pcol_ff, bcol_ff;
   logic [ROW_W-1:0] prow_ff, brow_ff;
   logic [BIB_W-1:0] cib_ff, rib_ff;

   logic [MEM_W-1:0] mem [MAX_WIDTH];
   logic [MEM_W-1:0] rd_ff;

   bap_req_type      pix_ff;
   logic             emit_ff, first_ff, fdone_ff;
   logic [COL_W-1:0] addr_ff;
   logic [ROW_W-1:0] orow_ff;
   logic [AREA_W-1:0] area_ff;

   logic [SUM_W-1:0]  quo_ff [3];
   logic [AREA_W-1:0] rem_ff [3];
   logic [SUM_W-1:0]  sum_in [3];
   logic [SUM_W-1:0]  quo_in [3];
   logic [AREA_W-1:0] rem_in [3];
   logic [DCNT_W-1:0] dcnt_ff;

   logic             rsp_valid_ff;
   bap_rsp_type      rsp_ff;

   logic end_row, last_frow, end_frame, cwrap, rwrap, emit, first;
   logic [MEM_W-1:0] wr_word;

   // clamp registers into their legal ranges
   always_comb begin
      bs_eff = bs_reg_ff;
      if (bs_reg_ff == '0) bs_eff = BS_REG_W'(1);
      else if (bs_reg_ff > BS_REG_W'(MAX_BLOCK)) bs_eff = BS_REG_W'(MAX_BLOCK);
      w_eff = w_reg_ff;
      if (w_reg_ff == '0) w_eff = DIM_REG_W'(1);
      else if (w_reg_ff > DIM_REG_W'(MAX_WIDTH)) w_eff = DIM_REG_W'(MAX_WIDTH);
      h_eff = h_reg_ff;
      if (h_reg_ff == '0) h_eff = DIM_REG_W'(1);
      else if (h_reg_ff > DIM_REG_W'(MAX_HEIGHT)) h_eff = DIM_REG_W'(MAX_HEIGHT);
   end

   always_comb begin
      end_row   = (DIM_REG_W'(pcol_ff) + DIM_REG_W'(1)) >= w_eff;
      last_frow = (DIM_REG_W'(prow_ff) + DIM_REG_W'(1)) >= h_eff;
      end_frame = end_row && last_frow;
      cwrap     = (BS_REG_W'(cib_ff) + BS_REG_W'(1)) >= bs_eff;
      rwrap     = (BS_REG_W'(rib_ff) + BS_REG_W'(1)) >= bs_eff;
      emit      = (cwrap || end_row) && (rwrap || last_frow);
      // first pixel of a block starts its sum from zero
      first     = (cib_ff == '0) && (rib_ff == '0);
   end

   // config registers and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         bs_reg_ff <= BS_REG_W'(8);
         w_reg_ff  <= DIM_REG_W'(640);
         h_reg_ff  <= DIM_REG_W'(480);
         pcol_ff <= '0; prow_ff <= '0; cib_ff <= '0; rib_ff <= '0;
         bcol_ff <= '0; brow_ff <= '0;
      end else if (csr_wr_en && (csr_index == CSR_BLOCK_SIZE || csr_index == CSR_IMAGE_WIDTH
                                 || csr_index == CSR_IMAGE_HEIGHT)) begin
         case (csr_index)
            CSR_BLOCK_SIZE:   bs_reg_ff <= csr_wdata[BS_REG_W-1:0];
            CSR_IMAGE_WIDTH:  w_reg_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: h_reg_ff  <= csr_wdata;
            default: ;
         endcase
         pcol_ff <= '0; prow_ff <= '0; cib_ff <= '0; rib_ff <= '0;
         bcol_ff <= '0; brow_ff <= '0;
      end else if (cmd.accept) begin
         if (end_row) begin
            pcol_ff <= '0;
            cib_ff  <= '0;
            bcol_ff <= '0;
            if (end_frame) begin
               prow_ff <= '0;
               rib_ff  <= '0;
               brow_ff <= '0;
            end else begin
               prow_ff <= prow_ff + ROW_W'(1);
               if (rwrap) begin
                  rib_ff  <= '0;
                  brow_ff <= brow_ff + ROW_W'(1);
               end else begin
                  rib_ff <= rib_ff + BIB_W'(1);
               end
            end
         end else begin
            pcol_ff <= pcol_ff + COL_W'(1);
            if (cwrap) begin
               cib_ff  <= '0;
               bcol_ff <= bcol_ff + COL_W'(1);
            end else begin
               cib_ff <= cib_ff + BIB_W'(1);
            end
         end
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff   <= req_data;
         emit_ff  <= emit;
         first_ff <= first;
         fdone_ff <= end_frame;
         addr_ff  <= bcol_ff;
         orow_ff  <= brow_ff;
         area_ff  <= AREA_W'(bs_eff * bs_eff);
      end
   end

   // column sum memory, read on accept, written on update
   always_ff @(posedge clock) begin
      if (cmd.accept) rd_ff <= mem[bcol_ff];
      if (cmd.update) mem[addr_ff] <= wr_word;
   end

   always_comb begin
      sum_in[0] = (first_ff ? '0 : rd_ff[3*SUM_W-1:2*SUM_W]) + SUM_W'(pix_ff.red_in);
      sum_in[1] = (first_ff ? '0 : rd_ff[2*SUM_W-1:SUM_W])   + SUM_W'(pix_ff.green_in);
      sum_in[2] = (first_ff ? '0 : rd_ff[SUM_W-1:0])         + SUM_W'(pix_ff.blue_in);
      wr_word   = {sum_in[0], sum_in[1], sum_in[2]};
   end

   // restoring divider, one quotient bit per cycle on three lanes
   always_comb begin
      logic [AREA_W:0] trial;
      for (int i = 0; i < 3; i++) begin
         trial = {rem_ff[i], quo_ff[i][SUM_W-1]};
         if (trial >= {1'b0, area_ff}) begin
            rem_in[i] = AREA_W'(trial - {1'b0, area_ff});
            quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b1};
         end else begin
            rem_in[i] = trial[AREA_W-1:0];
            quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         dcnt_ff <= DCNT_W'(SUM_W - 1);
         for (int i = 0; i < 3; i++) begin
            quo_ff[i] <= sum_in[i];
            rem_ff[i] <= '0;
         end
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff - DCNT_W'(1);
         for (int i = 0; i < 3; i++) begin
            quo_ff[i] <= quo_in[i];
            rem_ff[i] <= rem_in[i];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.block_column  <= addr_ff;
         rsp_ff.block_row     <= orow_ff;
         rsp_ff.red_average   <= quo_ff[0][7:0];
         rsp_ff.green_average <= quo_ff[1][7:0];
         rsp_ff.blue_average  <= quo_ff[2][7:0];
         rsp_ff.frame_done    <= fdone_ff;
      end
   end

   assign status.emit     = emit_ff;
   assign status.div_last = (dcnt_ff == '0);
   assign status.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

// File: sv/block_average_pixelate_core.sv
// a pixel is accepted, then its column sum is updated; a pixel that closes a block then runs the divide
// a block result reaches the output register after the divide, once that register is free
// one pixel in flight at a time; the 20-bit restoring divider sets the block cost
// a finished block waits in the output register while the next pixel is taken
// reset restores block size 8, 640 by 480 and restarts the frame, no clearing pass
`include "block_average_pixelate_core_assert.svh"
module block_average_pixelate_core import bap_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_REG_W-1:0] csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bap_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bap_rsp_type          rsp_data
);

   // command and status between controller and datapath
   bap_cmd_type    cmd;
   bap_status_type status;

   // sequencer: accept, read-modify-write, divide, hand to output register
   bap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // counters, per block column sums, divider lanes
   bap_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // an accepted transaction blocks the input the next cycle
   `BAP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // a new result only appears when the controller was busy
   `BAP_ASSERT_IMPLY(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule
